@@ sv/pfw_pkg.sv @@
// pfw_pkg: shared types, register indexes, pipeline depths and the output
// saturation function of the pixel filter weight block
// no dependencies
package pfw_pkg;

    // filter selection held in the kind register
    typedef enum logic [1:0] {
        KIND_BOX    = 2'd0,
        KIND_TRI    = 2'd1,
        KIND_CATROM = 2'd2,
        KIND_MITCH  = 2'd3
    } t_kind;

    // configuration register indexes
    localparam logic [1:0] CFG_KIND = 2'd0;
    localparam logic [1:0] CFG_XW   = 2'd1;
    localparam logic [1:0] CFG_YW   = 2'd2;

    // pipeline shape
    localparam int MD_STEPS  = 32;  // mitchell quotient bits
    localparam int TV_STEPS  = 16;  // triangle quotient bits
    localparam int SQ_STEPS  = 17;  // square root result bits
    localparam int CAT_DLY   = 17;  // catmull-rom alignment
    localparam int TRI_DLY   = 21;  // triangle alignment
    localparam int VLD_DEPTH = 42;  // valid chain depth, accept to result strobe

    // one finished weight
    typedef struct packed {
        logic        clip;
        logic [15:0] w;
    } t_wres;

    // apply sign to a magnitude and saturate to signed 16 bits
    function automatic t_wres f_sat(input logic neg, input logic [31:0] mag);
        t_wres res;
        if (neg) begin
            if (mag > 32'd32768) begin
                res.clip = 1'b1;
                res.w    = 16'h8000;
            end else begin
                res.clip = 1'b0;
                res.w    = 16'(32'd0 - mag);
            end
        end else begin
            if (mag > 32'd32767) begin
                res.clip = 1'b1;
                res.w    = 16'h7FFF;
            end else begin
                res.clip = 1'b0;
                res.w    = mag[15:0];
            end
        end
        return res;
    endfunction

endpackage

@@ sv/pixel_filter_weight.sv @@
// pixel_filter_weight: reconstruction filter weight, box, triangle, radial
// catmull-rom and mitchell-netravali, as one fixed-latency pipeline
// depends on pfw_pkg
//
// One sample offset (i_dx, i_dy) is taken on every clock at which start is
// high; busy stays low, so a new request may follow in every cycle. The
// weight comes out on o_weight / o_clipped with o_valid exactly 42 cycles
// after the request edge, in request order, and must be taken in that cycle.
// The latency is set by the mitchell path: a cubic built from registered
// multiplies, then a restoring divider that resolves one quotient bit per
// stage over 32 stages, then the product of the two axis factors. The other
// filters run in parallel and are delayed to the same depth. The filter kind
// and widths should only be written while no request is in flight.
module pixel_filter_weight (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] i_dx,
    input  logic signed [15:0] i_dy,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    output logic               o_valid,
    output logic signed [15:0] o_weight,
    output logic               o_clipped
);
    import pfw_pkg::*;

    localparam logic [63:0]        MP_HALF = 64'h0000_0008_0000_0000;
    localparam logic [47:0]        CR_HALF = 48'h0000_1000_0000;
    localparam logic signed [47:0] CR_TWO  = 48'sh0200_0000_0000;
    localparam logic signed [47:0] CR_FOUR = 48'sh0400_0000_0000;

    function automatic logic signed [57:0] sx58(input logic [50:0] v);
        return signed'(58'(v));
    endfunction

    // configuration registers
    t_kind       r_kind;
    logic [15:0] r_xw;
    logic [15:0] r_yw;

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= KIND_MITCH;
            r_xw   <= 16'd8192;
            r_yw   <= 16'd8192;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_KIND: r_kind <= t_kind'(i_cfg_data[1:0]);
                CFG_XW:   r_xw   <= i_cfg_data;
                CFG_YW:   r_yw   <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    // valid chain
    logic                 accept;
    logic [VLD_DEPTH-1:0] r_vld;

    assign accept  = start && !busy;
    assign o_valid = r_vld[VLD_DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[VLD_DEPTH-2:0], accept};
        end
    end

    // input register
    logic signed [15:0] r_dx;
    logic signed [15:0] r_dy;

    always_ff @(posedge i_clk) begin
        r_dx <= i_dx;
        r_dy <= i_dy;
    end

    // magnitudes and effective widths
    logic [15:0] abs_x, abs_y, wx, wy;
    logic [15:0] ax [2];
    logic [15:0] wv [2];

    always_comb begin
        abs_x = r_dx[15] ? (~r_dx + 16'd1) : r_dx;
        abs_y = r_dy[15] ? (~r_dy + 16'd1) : r_dy;
        wx    = (r_xw == 16'd0) ? 16'd1 : r_xw;
        wy    = (r_yw == 16'd0) ? 16'd1 : r_yw;
        ax[0] = abs_x;
        ax[1] = abs_y;
        wv[0] = wx;
        wv[1] = wy;
    end

    // ------------------------------------------------------------------
    // mitchell-netravali, one lane per axis
    // ------------------------------------------------------------------
    logic [16:0]        r_m1_t   [2];
    logic [15:0]        r_m1_w   [2];
    logic [33:0]        r_m1_tt  [2];
    logic [32:0]        r_m1_tw  [2];
    logic [31:0]        r_m1_ww  [2];
    logic               r_m1_gt  [2];
    logic [50:0]        r_m2_ttt [2];
    logic [49:0]        r_m2_ttw [2];
    logic [48:0]        r_m2_tww [2];
    logic [47:0]        r_m2_www [2];
    logic               r_m2_gt  [2];
    logic signed [57:0] r_m3_n   [2];
    logic [52:0]        r_m3_d   [2];
    logic [57:0]        m4_abs   [2];

    logic [52:0] r_md_rem  [2][0:MD_STEPS];
    logic [6:0]  r_md_lo   [2][0:MD_STEPS];
    logic [52:0] r_md_d    [2][0:MD_STEPS];
    logic [31:0] r_md_q    [2][0:MD_STEPS];
    logic        r_md_neg  [2][0:MD_STEPS];
    logic        r_md_over [2][0:MD_STEPS];
    logic [53:0] md_sh     [2][1:MD_STEPS];
    logic        md_ge     [2][1:MD_STEPS];

    logic [31:0] r_mr_q   [2];
    logic        r_mr_neg [2];
    logic [63:0] r_mp_p;
    logic        r_mp_neg;
    logic [27:0] r_mm_mag;
    logic        r_mm_neg;
    t_wres       r_ms;

    // divider step compare
    always_comb begin
        for (int g = 0; g < 2; g++) begin
            m4_abs[g] = r_m3_n[g][57] ? 58'(-r_m3_n[g]) : 58'(r_m3_n[g]);
            for (int k = 1; k <= MD_STEPS; k++) begin
                md_sh[g][k] = {r_md_rem[g][k-1], r_md_lo[g][k-1][6]};
                md_ge[g][k] = md_sh[g][k] >= {1'b0, r_md_d[g][k-1]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int g = 0; g < 2; g++) begin
            // powers of t = 2|d| and w
            r_m1_t[g]  <= {ax[g], 1'b0};
            r_m1_w[g]  <= wv[g];
            r_m1_tt[g] <= {ax[g], 1'b0} * {ax[g], 1'b0};
            r_m1_tw[g] <= {ax[g], 1'b0} * wv[g];
            r_m1_ww[g] <= wv[g] * wv[g];
            r_m1_gt[g] <= {ax[g], 1'b0} > {1'b0, wv[g]};
            // cubic terms
            r_m2_ttt[g] <= r_m1_tt[g] * r_m1_t[g];
            r_m2_ttw[g] <= r_m1_tt[g] * r_m1_w[g];
            r_m2_tww[g] <= r_m1_tw[g] * r_m1_w[g];
            r_m2_www[g] <= r_m1_ww[g] * r_m1_w[g];
            r_m2_gt[g]  <= r_m1_gt[g];
            // numerator and denominator of the factor
            if (r_m2_gt[g]) begin
                r_m3_n[g] <= 58'sd36 * sx58(51'(r_m2_ttw[g]))
                           - 58'sd7  * sx58(r_m2_ttt[g])
                           - 58'sd60 * sx58(51'(r_m2_tww[g]))
                           + 58'sd32 * sx58(51'(r_m2_www[g]));
            end else begin
                r_m3_n[g] <= 58'sd21 * sx58(r_m2_ttt[g])
                           - 58'sd36 * sx58(51'(r_m2_ttw[g]))
                           + 58'sd16 * sx58(51'(r_m2_www[g]));
            end
            r_m3_d[g] <= r_m2_www[g] * 53'd18;
            // divider entry, integer part over 127 saturates
            r_md_rem[g][0]  <= 53'(m4_abs[g][56:7]);
            r_md_lo[g][0]   <= m4_abs[g][6:0];
            r_md_d[g][0]    <= r_m3_d[g];
            r_md_q[g][0]    <= '0;
            r_md_neg[g][0]  <= r_m3_n[g][57];
            r_md_over[g][0] <= {3'b0, m4_abs[g][56:7]} >= r_m3_d[g];
            // one quotient bit per stage
            for (int k = 1; k <= MD_STEPS; k++) begin
                r_md_rem[g][k]  <= md_ge[g][k] ? 53'(md_sh[g][k] - {1'b0, r_md_d[g][k-1]})
                                               : md_sh[g][k][52:0];
                r_md_q[g][k]    <= {r_md_q[g][k-1][30:0], md_ge[g][k]};
                r_md_lo[g][k]   <= {r_md_lo[g][k-1][5:0], 1'b0};
                r_md_d[g][k]    <= r_md_d[g][k-1];
                r_md_neg[g][k]  <= r_md_neg[g][k-1];
                r_md_over[g][k] <= r_md_over[g][k-1];
            end
            // round factor to q24
            r_mr_q[g]   <= r_md_over[g][MD_STEPS] ? 32'h8000_0000
                         : 32'((33'(r_md_q[g][MD_STEPS]) + 33'd1) >> 1);
            r_mr_neg[g] <= r_md_neg[g][MD_STEPS];
        end
        // product of the two factors, rounded to q12
        r_mp_p   <= r_mr_q[0] * r_mr_q[1];
        r_mp_neg <= r_mr_neg[0] ^ r_mr_neg[1];
        r_mm_mag <= 28'((r_mp_p + MP_HALF) >> 36);
        r_mm_neg <= r_mp_neg;
        r_ms     <= f_sat(r_mm_neg, 32'(r_mm_mag));
    end

    // ------------------------------------------------------------------
    // radial catmull-rom
    // ------------------------------------------------------------------
    logic [31:0] r_c1_xx, r_c1_yy;
    logic [31:0] c2_s;
    logic [18:0] r_sq_rem  [0:SQ_STEPS];
    logic [16:0] r_sq_root [0:SQ_STEPS];
    logic [33:0] r_sq_v    [0:SQ_STEPS];
    logic [25:0] r_sq_s    [0:SQ_STEPS];
    logic        r_sq_far  [0:SQ_STEPS];
    logic [20:0] sq_sh     [1:SQ_STEPS];
    logic [20:0] sq_trial  [1:SQ_STEPS];
    logic        sq_ge     [1:SQ_STEPS];

    logic [42:0]        r_cm_rs;
    logic [16:0]        r_cm_r;
    logic [25:0]        r_cm_s;
    logic               r_cm_near, r_cm_far;
    logic signed [47:0] cv_rs, cv_s16, cv_r27;
    logic signed [47:0] r_cv_v;
    logic               r_cv_far;
    logic [47:0]        cv_abs;
    logic [18:0]        r_cmm_mag;
    logic               r_cmm_neg;
    t_wres              r_cs;
    t_wres              r_cdl [0:CAT_DLY-1];

    always_comb begin
        c2_s = r_c1_xx + r_c1_yy;
        for (int k = 1; k <= SQ_STEPS; k++) begin
            sq_sh[k]    = {r_sq_rem[k-1], r_sq_v[k-1][33:32]};
            sq_trial[k] = {2'b0, r_sq_root[k-1], 2'b01};
            sq_ge[k]    = sq_sh[k] >= sq_trial[k];
        end
        cv_rs  = signed'(48'(r_cm_rs));
        cv_s16 = signed'(48'({r_cm_s, 16'b0}));
        cv_r27 = signed'(48'({r_cm_r, 27'b0}));
        cv_abs = r_cv_v[47] ? 48'(-r_cv_v) : 48'(r_cv_v);
    end

    always_ff @(posedge i_clk) begin
        // squared radius in q8.24
        r_c1_xx <= abs_x * abs_x;
        r_c1_yy <= abs_y * abs_y;
        // square root entry, radius 2 and beyond gives zero
        r_sq_rem[0]  <= '0;
        r_sq_root[0] <= '0;
        r_sq_v[0]    <= {c2_s[25:0], 8'b0};
        r_sq_s[0]    <= c2_s[25:0];
        r_sq_far[0]  <= |c2_s[31:26];
        // one root bit per stage
        for (int k = 1; k <= SQ_STEPS; k++) begin
            r_sq_rem[k]  <= sq_ge[k] ? 19'(sq_sh[k] - sq_trial[k]) : sq_sh[k][18:0];
            r_sq_root[k] <= {r_sq_root[k-1][15:0], sq_ge[k]};
            r_sq_v[k]    <= {r_sq_v[k-1][31:0], 2'b0};
            r_sq_s[k]    <= r_sq_s[k-1];
            r_sq_far[k]  <= r_sq_far[k-1];
        end
        // r times r squared
        r_cm_rs   <= r_sq_root[SQ_STEPS] * r_sq_s[SQ_STEPS];
        r_cm_r    <= r_sq_root[SQ_STEPS];
        r_cm_s    <= r_sq_s[SQ_STEPS];
        r_cm_near <= (r_sq_s[SQ_STEPS][25:24] == 2'b0);
        r_cm_far  <= r_sq_far[SQ_STEPS];
        // inner or outer polynomial, q40
        if (r_cm_near) begin
            r_cv_v <= 48'sd3 * cv_rs - 48'sd5 * cv_s16 + CR_TWO;
        end else begin
            r_cv_v <= 48'sd5 * cv_s16 - cv_rs - cv_r27 + CR_FOUR;
        end
        r_cv_far <= r_cm_far;
        // round to q12
        r_cmm_mag <= r_cv_far ? '0 : 19'((cv_abs + CR_HALF) >> 29);
        r_cmm_neg <= r_cv_far ? 1'b0 : r_cv_v[47];
        r_cs      <= f_sat(r_cmm_neg, 32'(r_cmm_mag));
        // align with the mitchell lane
        r_cdl[0] <= r_cs;
        for (int k = 1; k < CAT_DLY; k++) begin
            r_cdl[k] <= r_cdl[k-1];
        end
    end

    // ------------------------------------------------------------------
    // triangle
    // ------------------------------------------------------------------
    logic               t1_sel;
    logic signed [17:0] r_t1_num;
    logic [15:0]        r_t1_w;
    logic [16:0]        t2_abs;
    logic [28:0]        t2_m;

    logic [16:0] r_tv_rem  [0:TV_STEPS];
    logic [15:0] r_tv_lo   [0:TV_STEPS];
    logic [15:0] r_tv_w    [0:TV_STEPS];
    logic [15:0] r_tv_q    [0:TV_STEPS];
    logic        r_tv_neg  [0:TV_STEPS];
    logic        r_tv_over [0:TV_STEPS];
    logic [17:0] tv_sh     [1:TV_STEPS];
    logic        tv_ge     [1:TV_STEPS];
    t_wres       r_ts;
    t_wres       r_tdl [0:TRI_DLY-1];

    always_comb begin
        t1_sel = abs_x > abs_y;
        t2_abs = r_t1_num[17] ? 17'(-r_t1_num) : 17'(r_t1_num);
        t2_m   = {t2_abs, 12'b0} + 29'(r_t1_w >> 1);
        for (int k = 1; k <= TV_STEPS; k++) begin
            tv_sh[k] = {r_tv_rem[k-1], r_tv_lo[k-1][15]};
            tv_ge[k] = tv_sh[k] >= {2'b0, r_tv_w[k-1]};
        end
    end

    always_ff @(posedge i_clk) begin
        // larger offset picks the axis, equal offsets use y
        r_t1_num <= t1_sel ? (signed'({2'b0, wx}) - signed'({1'b0, abs_x, 1'b0}))
                           : (signed'({2'b0, wy}) - signed'({1'b0, abs_y, 1'b0}));
        r_t1_w   <= t1_sel ? wx : wy;
        // divider entry with half divisor added for rounding
        r_tv_rem[0]  <= 17'(t2_m[28:16]);
        r_tv_lo[0]   <= t2_m[15:0];
        r_tv_w[0]    <= r_t1_w;
        r_tv_q[0]    <= '0;
        r_tv_neg[0]  <= r_t1_num[17];
        r_tv_over[0] <= t2_m[28:16] >= r_t1_w;
        // one quotient bit per stage
        for (int k = 1; k <= TV_STEPS; k++) begin
            r_tv_rem[k]  <= tv_ge[k] ? 17'(tv_sh[k] - {2'b0, r_tv_w[k-1]}) : tv_sh[k][16:0];
            r_tv_q[k]    <= {r_tv_q[k-1][14:0], tv_ge[k]};
            r_tv_lo[k]   <= {r_tv_lo[k-1][14:0], 1'b0};
            r_tv_w[k]    <= r_tv_w[k-1];
            r_tv_neg[k]  <= r_tv_neg[k-1];
            r_tv_over[k] <= r_tv_over[k-1];
        end
        r_ts <= f_sat(r_tv_neg[TV_STEPS],
                      r_tv_over[TV_STEPS] ? 32'h0001_0000 : {16'b0, r_tv_q[TV_STEPS]});
        // align with the mitchell lane
        r_tdl[0] <= r_ts;
        for (int k = 1; k < TRI_DLY; k++) begin
            r_tdl[k] <= r_tdl[k-1];
        end
    end

    // ------------------------------------------------------------------
    // output select
    // ------------------------------------------------------------------
    t_wres r_out;

    always_ff @(posedge i_clk) begin
        case (r_kind)
            KIND_BOX:    r_out <= '{clip: 1'b0, w: 16'd4096};
            KIND_TRI:    r_out <= r_tdl[TRI_DLY-1];
            KIND_CATROM: r_out <= r_cdl[CAT_DLY-1];
            default:     r_out <= r_ms;
        endcase
    end

    assign o_weight  = signed'(r_out.w);
    assign o_clipped = r_out.clip;

endmodule

@@ sv/pfw_check.sv @@
// pfw_check: port-level checks on the pixel filter weight block, bound to it
// depends on pfw_pkg and pixel_filter_weight
module pfw_check (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_valid,
    input logic signed [15:0] o_weight,
    input logic               o_clipped
);
    import pfw_pkg::*;

    // every result comes from a request a fixed latency earlier
    a_result_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, VLD_DEPTH))
        else $error("result without a matching request");

    // a clipped weight sits at one of the range limits
    a_clip_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_clipped) |-> (o_weight == 16'sh7FFF || o_weight == -16'sh8000))
        else $error("clipped weight not at a range limit");

    // reset flushes the pipeline, no strobe in the first cycle after release
    a_reset_flush: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> !o_valid)
        else $error("result strobe right after reset");

endmodule

bind pixel_filter_weight pfw_check u_pfw_check (.*);

@@ tb/tb_top.sv @@
// tb_top: self-checking bench for pixel_filter_weight, a directed table of
// offsets and filter settings, then random offsets over phases of idling
// depends on pfw_pkg and pixel_filter_weight
module tb_top;
    import pfw_pkg::*;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [15:0] i_dx = '0;
    logic signed [15:0] i_dy = '0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index = CFG_KIND;
    logic [15:0]        i_cfg_data = '0;
    logic               o_valid;
    logic signed [15:0] o_weight;
    logic               o_clipped;

    typedef struct {
        logic [15:0] w;
        logic        clip;
    } t_weight_exp;

    typedef struct {
        t_kind       kind;
        logic [15:0] xw;
        logic [15:0] yw;
        logic [15:0] dx;
        logic [15:0] dy;
        bit          typed;
        logic [15:0] ew;
        logic        ec;
    } t_row;

    t_weight_exp weights_due[$];
    t_kind       cur_kind = KIND_MITCH;
    logic [15:0] cur_xw = 16'd8192;
    logic [15:0] cur_yw = 16'd8192;
    int          mismatches = 0;

    pixel_filter_weight dut (.*);

    // clock, period 10
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // safety stop
    initial begin
        #5000000;
        $display("Regression FAIL");
        $finish;
    end

    // round a magnitude shift to nearest, ties away from zero
    function automatic longint rnd_shift(longint v, int sh);
        longint unsigned m;
        m = (v < 0) ? -v : v;
        m = (m + (64'd1 << (sh - 1))) >> sh;
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint rnd_div(longint num, longint den);
        longint unsigned m, q;
        m = (num < 0) ? -num : num;
        q = (m + den / 2) / den;
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // one mitchell axis factor in Q24, magnitude saturated to 2^31
    function automatic longint mitchell_axis(longint a, longint wd);
        longint t, n;
        longint unsigned d, m, q, rem;
        t = 2 * a;
        if (t > wd)
            n = -7 * t * t * t + 36 * t * t * wd - 60 * t * wd * wd + 32 * wd * wd * wd;
        else
            n = 21 * t * t * t - 36 * t * t * wd + 16 * wd * wd * wd;
        d = 18 * wd * wd * wd;
        m = (n < 0) ? -n : n;
        q = m / d;
        if (q >= 128) begin
            q = 64'd1 << 31;
        end else begin
            rem = m % d;
            for (int i = 0; i < 25; i++) begin
                rem <<= 1;
                q <<= 1;
                if (rem >= d) begin
                    rem -= d;
                    q |= 1;
                end
            end
            q = (q + 1) >> 1;
        end
        return (n < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint catrom_radial(longint dx, longint dy);
        longint s, r, v;
        s = dx * dx + dy * dy;
        if (s >= (64'sd4 << 24)) return 0;
        r = longint'(int_sqrt(longint'(s) << 8));
        if (s < (64'sd1 << 24))
            v = 3 * r * s - 5 * s * 65536 + (64'sd2 << 40);
        else
            v = -r * s + 5 * s * 65536 - 8 * r * (64'sd1 << 24) + (64'sd4 << 40);
        return rnd_shift(v, 29);
    endfunction

    // filter weight for one offset under the current register copy
    function automatic t_weight_exp filter_weight_of(logic signed [15:0] dx,
                                                     logic signed [15:0] dy);
        t_weight_exp e;
        longint a, b, wx, wy, g;
        a = (dx < 0) ? -longint'(dx) : longint'(dx);
        b = (dy < 0) ? -longint'(dy) : longint'(dy);
        wx = (cur_xw == 0) ? 1 : longint'(cur_xw);
        wy = (cur_yw == 0) ? 1 : longint'(cur_yw);
        case (cur_kind)
            KIND_BOX: g = 4096;
            KIND_TRI: begin
                if (a > b) g = rnd_div((wx - 2 * a) * 4096, wx);
                else       g = rnd_div((wy - 2 * b) * 4096, wy);
            end
            KIND_CATROM: g = catrom_radial(dx, dy);
            default: g = rnd_shift(mitchell_axis(a, wx) * mitchell_axis(b, wy), 36);
        endcase
        e.clip = 1'b1;
        if (g > 32767)       e.w = 16'h7FFF;
        else if (g < -32768) e.w = 16'h8000;
        else begin
            e.w = g[15:0];
            e.clip = 1'b0;
        end
        return e;
    endfunction

    // result check against the oldest expected weight
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (weights_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected weight %h clip %b", o_weight, o_clipped);
            end else begin
                t_weight_exp e;
                e = weights_due.pop_front();
                if (o_weight !== e.w || o_clipped !== e.clip) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("weight mismatch: exp %h/%b got %h/%b",
                                 e.w, e.clip, o_weight, o_clipped);
                end
            end
        end
    end

    // one request, with random idle cycles before it
    task automatic send_offset(logic [15:0] dx, logic [15:0] dy, int idle_pct,
                               bit typed, logic [15:0] ew, logic ec);
        t_weight_exp e;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_dx  <= dx;
        i_dy  <= dy;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (typed) begin
            e.w = ew;
            e.clip = ec;
        end else begin
            e = filter_weight_of(dx, dy);
        end
        weights_due.push_back(e);
    endtask

    // let every outstanding request finish
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (weights_due.size() != 0) @(posedge i_clk);
        repeat (VLD_DEPTH + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_KIND: cur_kind = t_kind'(data[1:0]);
            CFG_XW:   cur_xw = data;
            default:  cur_yw = data;
        endcase
    endtask

    task automatic set_filter(t_kind kind, logic [15:0] xw, logic [15:0] yw);
        write_reg(CFG_KIND, 16'(kind));
        write_reg(CFG_XW, xw);
        write_reg(CFG_YW, yw);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_width(bit extreme);
        if (extreme) begin
            case ($urandom_range(3))
                0: return 16'd0;
                1: return 16'd1;
                2: return 16'hFFFF;
                default: return 16'($urandom_range(1, 64));
            endcase
        end
        return 16'($urandom_range(1024, 16384));
    endfunction

    function automatic logic [15:0] pick_offset();
        if ($urandom_range(3) == 0) return 16'($urandom);
        return 16'($urandom_range(0, 24576) - 12288);
    endfunction

    // directed rows: extremes, every filter, zero width, catmull-rom edges
    t_row rows[] = '{
        '{KIND_MITCH,  16'd8192, 16'd8192, 16'd0,      16'd0,      0, 16'd0,    1'b0},
        '{KIND_MITCH,  16'd8192, 16'd8192, 16'd4096,   16'hF000,   0, 16'd0,    1'b0},
        '{KIND_BOX,    16'd8192, 16'd8192, 16'h8000,   16'h7FFF,   1, 16'd4096, 1'b0},
        '{KIND_BOX,    16'd8192, 16'd8192, 16'h7FFF,   16'h8000,   1, 16'd4096, 1'b0},
        '{KIND_TRI,    16'd8192, 16'd8192, 16'd0,      16'd0,      1, 16'd4096, 1'b0},
        '{KIND_TRI,    16'd8192, 16'd8192, 16'd2048,   16'd2048,   0, 16'd0,    1'b0},
        '{KIND_TRI,    16'd8192, 16'd8192, 16'd12288,  16'd100,    0, 16'd0,    1'b0},
        '{KIND_TRI,    16'd0,    16'd1,    16'h8000,   16'd0,      1, 16'h8000, 1'b1},
        '{KIND_TRI,    16'd0,    16'd1,    16'd0,      16'h7FFF,   1, 16'h8000, 1'b1},
        '{KIND_TRI,    16'hFFFF, 16'hFFFF, 16'h8000,   16'h7FFF,   0, 16'd0,    1'b0},
        '{KIND_CATROM, 16'd8192, 16'd8192, 16'd0,      16'd0,      1, 16'd4096, 1'b0},
        '{KIND_CATROM, 16'd8192, 16'd8192, 16'd4096,   16'd0,      1, 16'd0,    1'b0},
        '{KIND_CATROM, 16'd8192, 16'd8192, 16'd8192,   16'd0,      1, 16'd0,    1'b0},
        '{KIND_CATROM, 16'd8192, 16'd8192, 16'h8000,   16'h8000,   1, 16'd0,    1'b0},
        '{KIND_CATROM, 16'd8192, 16'd8192, 16'd2000,   16'hF500,   0, 16'd0,    1'b0},
        '{KIND_CATROM, 16'd8192, 16'd8192, 16'd6000,   16'd3000,   0, 16'd0,    1'b0},
        '{KIND_MITCH,  16'd1,    16'd0,    16'h8000,   16'h7FFF,   0, 16'd0,    1'b0},
        '{KIND_MITCH,  16'hFFFF, 16'hFFFF, 16'h8000,   16'd0,      0, 16'd0,    1'b0},
        '{KIND_MITCH,  16'd4096, 16'd4096, 16'd2048,   16'd3000,   0, 16'd0,    1'b0},
        '{KIND_MITCH,  16'd4096, 16'd4096, 16'd6000,   16'd0,      0, 16'd0,    1'b0}
    };

    // stimulus
    initial begin
        int idle_pct [4];
        idle_pct = '{0, 69, 0, 38};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) begin
            if (rows[k].kind != cur_kind || rows[k].xw != cur_xw || rows[k].yw != cur_yw) begin
                drain();
                set_filter(rows[k].kind, rows[k].xw, rows[k].yw);
            end
            send_offset(rows[k].dx, rows[k].dy, 0, rows[k].typed, rows[k].ew, rows[k].ec);
        end

        // random phases, each with its own filter setting and idling
        for (int p = 0; p < 12; p++) begin
            drain();
            set_filter(t_kind'(p % 4), pick_width(p >= 8), pick_width(p >= 8));
            for (int n = 0; n < 128; n++) begin
                if (p == 2 && n == 64) drain();
                send_offset(pick_offset(), pick_offset(), idle_pct[(p / 4 + p) % 4],
                            0, 16'd0, 1'b0);
            end
        end
        start <= 1'b0;

        // wait out the pipeline
        while (weights_due.size() != 0) @(posedge i_clk);
        repeat (VLD_DEPTH + 10) @(posedge i_clk);
        if (mismatches == 0 && weights_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
